// ===== rtl/aha_pkg.sv =====
// ----------------------------------------------------------------------------
// aha_pkg
// Shared types, constants and helpers of the arena heap allocator.
// ----------------------------------------------------------------------------
package aha_pkg;

    localparam int ARENA_BYTES   = 4096;
    localparam int HEADER_BYTES  = 16;
    localparam int CONTROL_BYTES = 48;
    localparam int STORE_WORDS   = ARENA_BYTES / 4;
    localparam int WORD_W        = $clog2(STORE_WORDS);
    localparam int APB_ADDR_W    = 4;

    typedef logic [WORD_W-1:0] idx_t;

    localparam idx_t       INIT_WORD = idx_t'(CONTROL_BYTES / 4);
    localparam logic [7:0] USED_FLAG = 8'h80;
    localparam logic [7:0] FREE_FLAG = 8'h00;

    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    localparam logic [1:0] REG_ARENA_LEN  = 2'd0;
    localparam logic [1:0] REG_FIT_MODE   = 2'd1;
    localparam logic [1:0] REG_GUARD      = 2'd2;
    localparam logic [1:0] REG_ALLOW_ZERO = 2'd3;

    typedef enum logic [1:0] {
        FN_ALLOC,
        FN_FREE,
        FN_QUERY,
        FN_INIT
    } func_t;

    typedef enum logic [2:0] {
        STS_OK,
        STS_NOMEM,
        STS_RANGE,
        STS_NOINIT,
        STS_NOBLK
    } status_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_INIT_W0,
        S_INIT_W1,
        S_A_WALK,
        S_A_W0,
        S_A_W1,
        S_A_W2,
        S_A_W3,
        S_L_RD,
        S_F_PREV,
        S_F_NX,
        S_F_NNW,
        S_F_WW,
        S_F_PV,
        S_F_NN2,
        S_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic [12:0] arena_len;
        logic [1:0]  fit_mode;
        logic [7:0]  guard_bytes;
        logic        allow_zero;
    } cfg_t;

    typedef struct packed {
        logic        rd_en;
        idx_t        rd_addr;
        logic        st_we;
        idx_t        st_waddr;
        logic [31:0] st_wdata;
        logic        hv_we;
        idx_t        hv_waddr;
        logic        hv_wdata;
    } mem_req_t;

    typedef struct packed {
        logic [31:0] word;
        logic        valid;
    } mem_rsp_t;

    typedef struct packed {
        status_t     status;
        logic [11:0] addr_out;
        logic [12:0] user_len;
        logic        owned;
        logic [11:0] front_guard_addr;
        logic [11:0] back_guard_addr;
        logic [8:0]  back_guard_len;
        logic [12:0] free_bytes;
        logic [8:0]  free_count;
        logic [12:0] used_bytes;
        logic [8:0]  used_count;
    } result_t;

    // Header word 0: flags in the top byte, size in the low bits.
    function automatic logic [31:0] hdr_word(logic [12:0] size, logic [7:0] flags);
        return {flags, 11'b0, size};
    endfunction

    // Word index of the header that follows a block of the given size.
    function automatic idx_t hdr_next(idx_t w, logic [12:0] size);
        logic [12:0] span;
        logic [12:0] sum;
        span = 13'(HEADER_BYTES) + size;
        sum  = 13'(w) + (span >> 2);
        return sum[WORD_W-1:0];
    endfunction

endpackage

// ===== rtl/aha_regs.sv =====
// ----------------------------------------------------------------------------
// aha_regs
// APB configuration registers of the arena heap allocator.
// ----------------------------------------------------------------------------
module aha_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [aha_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output aha_pkg::cfg_t                  cfg
);
    import aha_pkg::*;

    cfg_t cfg_reg;
    logic wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.arena_len   <= 13'(ARENA_BYTES);
            cfg_reg.fit_mode    <= '0;
            cfg_reg.guard_bytes <= '0;
            cfg_reg.allow_zero  <= 1'b0;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_ARENA_LEN:  cfg_reg.arena_len   <= pwdata[12:0];
                REG_FIT_MODE:   cfg_reg.fit_mode    <= pwdata[1:0];
                REG_GUARD:      cfg_reg.guard_bytes <= pwdata[7:0];
                REG_ALLOW_ZERO: cfg_reg.allow_zero  <= pwdata[0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_ARENA_LEN:  prdata = 32'(cfg_reg.arena_len);
            REG_FIT_MODE:   prdata = 32'(cfg_reg.fit_mode);
            REG_GUARD:      prdata = 32'(cfg_reg.guard_bytes);
            REG_ALLOW_ZERO: prdata = 32'(cfg_reg.allow_zero);
            default:        prdata = '0;
        endcase
    end

endmodule

// ===== rtl/aha_store.sv =====
// ----------------------------------------------------------------------------
// aha_store
// Header word memory and header valid memory, one registered read port.
// ----------------------------------------------------------------------------
module aha_store (
    input  logic              clk,
    input  aha_pkg::mem_req_t req,
    output aha_pkg::mem_rsp_t rsp
);
    import aha_pkg::*;

    logic [31:0] word_mem  [STORE_WORDS];
    logic        valid_mem [STORE_WORDS];
    logic [31:0] word_reg;
    logic        valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.st_we)
        begin
            word_mem[req.st_waddr] <= req.st_wdata;
        end
        if (req.rd_en)
        begin
            word_reg <= word_mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.hv_we)
        begin
            valid_mem[req.hv_waddr] <= req.hv_wdata;
        end
        if (req.rd_en)
        begin
            valid_reg <= valid_mem[req.rd_addr];
        end
    end

    assign rsp.word  = word_reg;
    assign rsp.valid = valid_reg;

endmodule

// ===== rtl/aha_ctrl.sv =====
// ----------------------------------------------------------------------------
// aha_ctrl
// Sequencer: walks the block chain, splits, merges and answers each item.
// ----------------------------------------------------------------------------
module aha_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  aha_pkg::cfg_t     cfg,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        func,
    input  logic [12:0]       req_bytes,
    input  logic [11:0]       addr,
    output logic              out_valid,
    input  logic              out_stall,
    output aha_pkg::result_t  result,
    output aha_pkg::mem_req_t mreq,
    input  aha_pkg::mem_rsp_t mrsp
);
    import aha_pkg::*;

    ctrl_state_t state_reg, state_next;
    idx_t        clr_idx_reg, clr_idx_next;
    logic        init_pend_reg, init_pend_next;
    func_t       func_reg, func_next;
    logic [12:0] req_reg, req_next;
    logic [11:0] addr_reg, addr_next;
    logic        heap_ready_reg, heap_ready_next;
    idx_t        first_reg, first_next;
    idx_t        last_reg, last_next;
    logic [12:0] free_total_reg, free_total_next;
    logic [8:0]  free_cnt_reg, free_cnt_next;
    logic [12:0] used_total_reg, used_total_next;
    logic [8:0]  used_cnt_reg, used_cnt_next;
    idx_t        cur_reg, cur_next;
    logic        have_reg, have_next;
    idx_t        found_reg, found_next;
    logic [12:0] fs_reg, fs_next;
    logic [12:0] realn_reg, realn_next;
    idx_t        w_reg, w_next;
    logic [12:0] size_reg, size_next;
    idx_t        prev_reg, prev_next;
    idx_t        nx_reg, nx_next;
    idx_t        nn_reg, nn_next;
    result_t     res_reg, res_next;
    result_t     out_reg, out_next;
    logic        out_valid_reg, out_valid_next;

    // Helpers shared by the next-state and output blocks
    logic [7:0]  g;
    logic [8:0]  g2;
    logic [12:0] arena_cap, init_min, init_size;
    logic [13:0] req_round, realn_full;
    logic [13:0] pad_diff;
    logic        alloc_go;
    logic [8:0]  loc_base;
    logic [11:0] loc_off;
    status_t     loc_status;
    idx_t        loc_w;
    logic [12:0] rd_size;
    logic        rd_used;
    logic [6:0]  rd_pad;
    logic        fit_best, fit_worst, fit_first;
    logic        walk_hit, walk_take, walk_end;
    idx_t        walk_next;
    logic [12:0] nextlen, minr, bsize;
    logic        do_split;
    idx_t        nw_idx, after_idx, nx_addr;
    logic [13:0] q_need;
    logic [8:0]  q_padg;
    logic [12:0] q_front, found_payload;
    logic        out_free;

    assign g      = {cfg.guard_bytes[7:2], 2'b00};
    assign g2     = {g, 1'b0};

    assign arena_cap = (cfg.arena_len > 13'(ARENA_BYTES)) ? 13'(ARENA_BYTES)
                                                          : {cfg.arena_len[12:2], 2'b00};
    assign init_min  = 13'(CONTROL_BYTES + HEADER_BYTES) + 13'(g2);
    assign init_size = arena_cap - 13'(CONTROL_BYTES + HEADER_BYTES);

    assign req_round  = (14'(req_reg) + 14'd3) & ~14'd3;
    assign realn_full = req_round + 14'(g2);
    assign pad_diff   = req_round - 14'(req_reg);
    assign alloc_go   = (realn_full <= 14'(free_total_reg))
                        && !(req_reg == '0 && !cfg.allow_zero);

    assign loc_base = 9'(HEADER_BYTES) + 9'(g);
    assign loc_off  = addr_reg - 12'(loc_base);
    assign loc_w    = loc_off[11:2];

    always_comb
    begin
        if (addr_reg < 12'(loc_base))
            loc_status = STS_RANGE;
        else if (loc_off < {first_reg, 2'b00} || loc_off > {last_reg, 2'b00})
            loc_status = STS_RANGE;
        else if (loc_off[1:0] != 2'b00)
            loc_status = STS_NOBLK;
        else
            loc_status = STS_OK;
    end

    assign rd_size = mrsp.word[12:0];
    assign rd_used = mrsp.word[31];
    assign rd_pad  = mrsp.word[30:24];

    assign fit_best  = (cfg.fit_mode == FIT_BEST);
    assign fit_worst = (cfg.fit_mode == FIT_WORST);
    assign fit_first = !fit_best && !fit_worst;

    assign walk_hit  = !rd_used && (rd_size >= realn_reg);
    assign walk_take = walk_hit && (!have_reg || (fit_best && fs_reg > rd_size)
                                              || (fit_worst && fs_reg < rd_size));
    assign walk_end  = (cur_reg == last_reg) || (walk_hit && fit_first);
    assign walk_next = hdr_next(cur_reg, rd_size);

    assign nextlen   = fs_reg - realn_reg;
    assign minr      = 13'(HEADER_BYTES) + 13'(g2);
    assign do_split  = (nextlen > minr) || (nextlen == minr && cfg.allow_zero);
    assign bsize     = do_split ? realn_reg : fs_reg;
    assign nw_idx    = hdr_next(found_reg, realn_reg);
    assign after_idx = hdr_next(found_reg, fs_reg);
    assign nx_addr   = hdr_next(w_reg, size_reg);

    assign q_need        = 14'(rd_pad) + 14'(g2);
    assign q_padg        = 9'(rd_pad) + 9'(g);
    assign q_front       = {1'b0, w_reg, 2'b00} + 13'(HEADER_BYTES);
    assign found_payload = {1'b0, found_reg, 2'b00} + 13'(HEADER_BYTES) + 13'(g);

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_idx_reg    <= '0;
            init_pend_reg  <= 1'b0;
            heap_ready_reg <= 1'b0;
            first_reg      <= '0;
            last_reg       <= '0;
            free_total_reg <= '0;
            free_cnt_reg   <= '0;
            used_total_reg <= '0;
            used_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            init_pend_reg  <= init_pend_next;
            heap_ready_reg <= heap_ready_next;
            first_reg      <= first_next;
            last_reg       <= last_next;
            free_total_reg <= free_total_next;
            free_cnt_reg   <= free_cnt_next;
            used_total_reg <= used_total_next;
            used_cnt_reg   <= used_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg  <= func_next;
        req_reg   <= req_next;
        addr_reg  <= addr_next;
        cur_reg   <= cur_next;
        have_reg  <= have_next;
        found_reg <= found_next;
        fs_reg    <= fs_next;
        realn_reg <= realn_next;
        w_reg     <= w_next;
        size_reg  <= size_next;
        prev_reg  <= prev_next;
        nx_reg    <= nx_next;
        nn_reg    <= nn_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    // Next state and datapath
    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        init_pend_next  = init_pend_reg;
        func_next       = func_reg;
        req_next        = req_reg;
        addr_next       = addr_reg;
        heap_ready_next = heap_ready_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        free_total_next = free_total_reg;
        free_cnt_next   = free_cnt_reg;
        used_total_next = used_total_reg;
        used_cnt_next   = used_cnt_reg;
        cur_next        = cur_reg;
        have_next       = have_reg;
        found_next      = found_reg;
        fs_next         = fs_reg;
        realn_next      = realn_reg;
        w_next          = w_reg;
        size_next       = size_reg;
        prev_next       = prev_reg;
        nx_next         = nx_reg;
        nn_next         = nn_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && out_stall;

        case (state_reg)
            S_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + idx_t'(1);
                if (clr_idx_reg == idx_t'(STORE_WORDS - 1))
                begin
                    state_next = init_pend_reg ? S_INIT_W0 : S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next  = func_t'(func);
                    req_next   = req_bytes;
                    addr_next  = addr;
                    res_next   = '0;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                state_next = S_DONE;
                if (func_reg == FN_INIT)
                begin
                    if (arena_cap < init_min)
                        res_next.status = STS_NOMEM;
                    else if (arena_cap == init_min && !cfg.allow_zero)
                        res_next.status = STS_RANGE;
                    else
                    begin
                        size_next      = init_size;
                        init_pend_next = 1'b1;
                        clr_idx_next   = '0;
                        state_next     = S_CLEAR;
                    end
                end
                else if (!heap_ready_reg)
                begin
                    res_next.status = STS_NOINIT;
                end
                else if (func_reg == FN_ALLOC)
                begin
                    if (realn_full > 14'(free_total_reg))
                        res_next.status = STS_NOMEM;
                    else if (!alloc_go)
                        res_next.status = STS_RANGE;
                    else
                    begin
                        realn_next = realn_full[12:0];
                        cur_next   = first_reg;
                        have_next  = 1'b0;
                        state_next = S_A_WALK;
                    end
                end
                else
                begin
                    res_next.status = loc_status;
                    if (loc_status == STS_OK)
                    begin
                        w_next     = loc_w;
                        state_next = S_L_RD;
                    end
                end
            end

            S_INIT_W0:
            begin
                init_pend_next  = 1'b0;
                heap_ready_next = 1'b1;
                first_next      = INIT_WORD;
                last_next       = INIT_WORD;
                free_total_next = size_reg;
                free_cnt_next   = 9'd1;
                used_total_next = '0;
                used_cnt_next   = '0;
                state_next      = S_INIT_W1;
            end

            S_INIT_W1:
            begin
                state_next = S_DONE;
            end

            S_A_WALK:
            begin
                if (walk_take)
                begin
                    have_next  = 1'b1;
                    found_next = cur_reg;
                    fs_next    = rd_size;
                end
                if (!walk_end)
                    cur_next = walk_next;
                else if (!(have_reg || walk_take))
                begin
                    res_next.status = STS_NOMEM;
                    state_next      = S_DONE;
                end
                else
                    state_next = S_A_W0;
            end

            S_A_W0:
            begin
                used_total_next   = used_total_reg + bsize;
                used_cnt_next     = used_cnt_reg + 9'd1;
                res_next.addr_out = found_payload[11:0];
                if (do_split)
                begin
                    free_total_next = free_total_reg - (realn_reg + 13'(HEADER_BYTES));
                    state_next      = S_A_W1;
                end
                else
                begin
                    free_total_next = free_total_reg - fs_reg;
                    free_cnt_next   = free_cnt_reg - 9'd1;
                    state_next      = S_DONE;
                end
            end

            S_A_W1:
            begin
                state_next = S_A_W2;
            end

            S_A_W2:
            begin
                if (found_reg == last_reg)
                begin
                    last_next  = nw_idx;
                    state_next = S_DONE;
                end
                else
                    state_next = S_A_W3;
            end

            S_A_W3:
            begin
                state_next = S_DONE;
            end

            S_L_RD:
            begin
                state_next = S_DONE;
                if (!mrsp.valid)
                    res_next.status = STS_NOBLK;
                else if (func_reg == FN_QUERY)
                begin
                    if (14'(rd_size) < q_need)
                        res_next.status = STS_RANGE;
                    else
                    begin
                        res_next.user_len = rd_size - q_need[12:0];
                        if (rd_used)
                        begin
                            res_next.owned            = 1'b1;
                            res_next.front_guard_addr = q_front[11:0];
                            res_next.back_guard_len   = q_padg;
                            res_next.back_guard_addr  =
                                12'(q_front + rd_size - 13'(q_padg));
                        end
                    end
                end
                else if (rd_used)
                begin
                    size_next       = rd_size;
                    used_total_next = used_total_reg - rd_size;
                    used_cnt_next   = used_cnt_reg - 9'd1;
                    free_total_next = free_total_reg + rd_size;
                    free_cnt_next   = free_cnt_reg + 9'd1;
                    state_next      = S_F_PREV;
                end
            end

            S_F_PREV:
            begin
                prev_next = mrsp.word[WORD_W-1:0];
                if (w_reg != last_reg)
                begin
                    nx_next    = nx_addr;
                    state_next = S_F_NX;
                end
                else
                    state_next = S_F_WW;
            end

            S_F_NX:
            begin
                state_next = S_F_WW;
                if (!rd_used)
                begin
                    size_next       = size_reg + rd_size + 13'(HEADER_BYTES);
                    nn_next         = hdr_next(nx_reg, rd_size);
                    free_total_next = free_total_reg + 13'(HEADER_BYTES);
                    free_cnt_next   = free_cnt_reg - 9'd1;
                    if (nx_reg == last_reg)
                        last_next = w_reg;
                    else
                        state_next = S_F_NNW;
                end
            end

            S_F_NNW:
            begin
                state_next = S_F_WW;
            end

            S_F_WW:
            begin
                state_next = (w_reg != first_reg) ? S_F_PV : S_DONE;
            end

            S_F_PV:
            begin
                state_next = S_DONE;
                if (!rd_used)
                begin
                    free_total_next = free_total_reg + 13'(HEADER_BYTES);
                    free_cnt_next   = free_cnt_reg - 9'd1;
                    if (w_reg == last_reg)
                        last_next = prev_reg;
                    else
                    begin
                        nn_next    = nx_addr;
                        state_next = S_F_NN2;
                    end
                end
            end

            S_F_NN2:
            begin
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_next            = res_reg;
                    out_next.free_bytes = free_total_reg;
                    out_next.free_count = free_cnt_reg;
                    out_next.used_bytes = used_total_reg;
                    out_next.used_count = used_cnt_reg;
                    out_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memory requests and handshake outputs
    always_comb
    begin
        mreq     = '0;
        in_stall = (state_reg != S_IDLE);

        case (state_reg)
            S_CLEAR:
            begin
                mreq.hv_we    = 1'b1;
                mreq.hv_waddr = clr_idx_reg;
                mreq.hv_wdata = 1'b0;
            end

            S_DISPATCH:
            begin
                if (heap_ready_reg && func_reg == FN_ALLOC && alloc_go)
                begin
                    mreq.rd_en   = 1'b1;
                    mreq.rd_addr = first_reg;
                end
                else if (heap_ready_reg && (func_reg == FN_FREE || func_reg == FN_QUERY)
                         && loc_status == STS_OK)
                begin
                    mreq.rd_en   = 1'b1;
                    mreq.rd_addr = loc_w;
                end
            end

            S_INIT_W0:
            begin
                mreq.st_we    = 1'b1;
                mreq.st_waddr = INIT_WORD;
                mreq.st_wdata = hdr_word(size_reg, FREE_FLAG);
                mreq.hv_we    = 1'b1;
                mreq.hv_waddr = INIT_WORD;
                mreq.hv_wdata = 1'b1;
            end

            S_INIT_W1:
            begin
                mreq.st_we    = 1'b1;
                mreq.st_waddr = INIT_WORD + idx_t'(1);
                mreq.st_wdata = '0;
            end

            S_A_WALK:
            begin
                // Chase the chain one header per cycle
                if (!walk_end)
                begin
                    mreq.rd_en   = 1'b1;
                    mreq.rd_addr = walk_next;
                end
            end

            S_A_W0:
            begin
                mreq.st_we    = 1'b1;
                mreq.st_waddr = found_reg;
                mreq.st_wdata = hdr_word(bsize, USED_FLAG | {1'b0, pad_diff[6:0]});
            end

            S_A_W1:
            begin
                mreq.st_we    = 1'b1;
                mreq.st_waddr = nw_idx;
                mreq.st_wdata = hdr_word(nextlen - 13'(HEADER_BYTES), FREE_FLAG);
                mreq.hv_we    = 1'b1;
                mreq.hv_waddr = nw_idx;
                mreq.hv_wdata = 1'b1;
            end

            S_A_W2:
            begin
                mreq.st_we    = 1'b1;
                mreq.st_waddr = nw_idx + idx_t'(1);
                mreq.st_wdata = 32'(found_reg);
            end

            S_A_W3:
            begin
                mreq.st_we    = 1'b1;
                mreq.st_waddr = after_idx + idx_t'(1);
                mreq.st_wdata = 32'(nw_idx);
            end

            S_L_RD:
            begin
                if (func_reg == FN_FREE && mrsp.valid && rd_used)
                begin
                    mreq.rd_en   = 1'b1;
                    mreq.rd_addr = w_reg + idx_t'(1);
                end
            end

            S_F_PREV:
            begin
                if (w_reg != last_reg)
                begin
                    mreq.rd_en   = 1'b1;
                    mreq.rd_addr = nx_addr;
                end
            end

            S_F_NX:
            begin
                // Absorb a free successor: drop its header
                if (!rd_used)
                begin
                    mreq.hv_we    = 1'b1;
                    mreq.hv_waddr = nx_reg;
                    mreq.hv_wdata = 1'b0;
                end
            end

            S_F_NNW:
            begin
                mreq.st_we    = 1'b1;
                mreq.st_waddr = nn_reg + idx_t'(1);
                mreq.st_wdata = 32'(w_reg);
            end

            S_F_WW:
            begin
                mreq.st_we    = 1'b1;
                mreq.st_waddr = w_reg;
                mreq.st_wdata = hdr_word(size_reg, FREE_FLAG);
                if (w_reg != first_reg)
                begin
                    mreq.rd_en   = 1'b1;
                    mreq.rd_addr = prev_reg;
                end
            end

            S_F_PV:
            begin
                if (!rd_used)
                begin
                    mreq.st_we    = 1'b1;
                    mreq.st_waddr = prev_reg;
                    mreq.st_wdata = hdr_word(rd_size + size_reg + 13'(HEADER_BYTES),
                                             FREE_FLAG);
                    mreq.hv_we    = 1'b1;
                    mreq.hv_waddr = w_reg;
                    mreq.hv_wdata = 1'b0;
                end
            end

            S_F_NN2:
            begin
                mreq.st_we    = 1'b1;
                mreq.st_waddr = nn_reg + idx_t'(1);
                mreq.st_wdata = 32'(prev_reg);
            end

            default:
            begin
                mreq = '0;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign result    = out_reg;

    a_chain_order: assert property (@(posedge clk) disable iff (!rst_n)
        heap_ready_reg |-> first_reg <= last_reg)
        else $error("first block lies beyond last block");

    a_walk_in_chain: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_A_WALK |-> cur_reg >= first_reg && cur_reg <= last_reg)
        else $error("chain walk left the block range");

    a_no_heap_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !heap_ready_reg |-> free_cnt_reg == '0 && used_cnt_reg == '0)
        else $error("block counts set before init");

    a_heap_has_block: assert property (@(posedge clk) disable iff (!rst_n)
        heap_ready_reg && state_reg == S_IDLE |-> (free_cnt_reg + used_cnt_reg) != '0)
        else $error("initialized heap holds no block");

    a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && out_free |=> out_valid_reg && state_reg == S_IDLE)
        else $error("finished item not loaded into output register");

endmodule

// ===== rtl/arena_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// arena_heap_allocator
// First, best or worst fit heap allocator over a 4 KiB arena with coalescing.
// ----------------------------------------------------------------------------
// One item at a time. After reset the header valid memory is swept before
// the first item is taken; a successful init runs the same sweep and then
// writes the first header. A failed init, or any other item before init,
// goes from dispatch straight to the result. Alloc reads one header per
// cycle along the block chain (the single read port of the header memory
// sets this), then writes the found header and, on a split, the new header
// and its links. Free reads the block and its neighbours and merges free
// ones; query reads one header. A finished result sits in an output register,
// so the next item is accepted while it waits to be taken.
module arena_heap_allocator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     func,
    input  logic [12:0]                    req_bytes,
    input  logic [11:0]                    addr,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [2:0]                     status,
    output logic [11:0]                    addr_out,
    output logic [12:0]                    user_len,
    output logic                           owned,
    output logic [11:0]                    front_guard_addr,
    output logic [11:0]                    back_guard_addr,
    output logic [8:0]                     back_guard_len,
    output logic [12:0]                    free_bytes,
    output logic [8:0]                     free_count,
    output logic [12:0]                    used_bytes,
    output logic [8:0]                     used_count,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [aha_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import aha_pkg::*;

    cfg_t     cfg;
    mem_req_t mreq;
    mem_rsp_t mrsp;
    result_t  result;

    aha_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    aha_store u_store (
        .clk (clk),
        .req (mreq),
        .rsp (mrsp)
    );

    aha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .req_bytes (req_bytes),
        .addr      (addr),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result),
        .mreq      (mreq),
        .mrsp      (mrsp)
    );

    assign status           = result.status;
    assign addr_out         = result.addr_out;
    assign user_len         = result.user_len;
    assign owned            = result.owned;
    assign front_guard_addr = result.front_guard_addr;
    assign back_guard_addr  = result.back_guard_addr;
    assign back_guard_len   = result.back_guard_len;
    assign free_bytes       = result.free_bytes;
    assign free_count       = result.free_count;
    assign used_bytes       = result.used_bytes;
    assign used_count       = result.used_count;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the arena heap allocator: a directed pass over
// init failures, the guard, rounding and coalescing corner cases, then mixed
// random alloc/free/query/init traffic under several fit, guard and arena
// settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import aha_pkg::*;

    typedef struct {
        func_t       fn;
        logic [12:0] req;
        logic [11:0] ad;
    } heap_op_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  func = 2'd0;
    logic [12:0] req_bytes = 13'd0;
    logic [11:0] addr = 12'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [11:0] addr_out;
    logic [12:0] user_len;
    logic        owned;
    logic [11:0] front_guard_addr;
    logic [11:0] back_guard_addr;
    logic [8:0]  back_guard_len;
    logic [12:0] free_bytes;
    logic [8:0]  free_count;
    logic [12:0] used_bytes;
    logic [8:0]  used_count;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    arena_heap_allocator dut (.*);

    // Shadow heap
    int unsigned hdr_mem [STORE_WORDS];
    bit          hdr_ok [STORE_WORDS];
    int unsigned first_w, last_w, ready;
    int unsigned free_total, free_blocks, used_total, used_blocks;
    int unsigned cfg_len = 4096, cfg_fit = 0, cfg_guard = 0, cfg_zero = 0;

    heap_op_t    pending_ops[$];
    result_t     expected_results[$];
    int unsigned live_addrs[$];
    int unsigned last_freed = 0;
    int          send_idle = 0, recv_idle = 0;
    int          errors = 0;
    int          n_items = 0, n_alloc_ok = 0, n_free_ok = 0, n_query_ok = 0, n_init_ok = 0;

    initial forever #4 clk = ~clk;

    function automatic int unsigned rd(int unsigned w);
        return (w < STORE_WORDS) ? hdr_mem[w] : 0;
    endfunction

    function automatic int unsigned hsz(int unsigned w);
        return rd(w) & 32'h00FF_FFFF;
    endfunction

    function automatic int unsigned hfl(int unsigned w);
        return rd(w) >> 24;
    endfunction

    function automatic int unsigned hnx(int unsigned w);
        return w + (HEADER_BYTES + hsz(w)) / 4;
    endfunction

    task automatic wr(int unsigned w, int unsigned v);
        if (w < STORE_WORDS) hdr_mem[w] = v;
    endtask

    task automatic put_hdr(int unsigned w, int unsigned size, int unsigned flags,
                           int unsigned prev);
        wr(w, (size & 32'h00FF_FFFF) | ((flags & 8'hFF) << 24));
        wr(w + 1, prev);
        if (w < STORE_WORDS) hdr_ok[w] = 1'b1;
    endtask

    function automatic int unsigned locate(int unsigned a, int unsigned g,
                                           output int unsigned w);
        int unsigned base, off;
        base = HEADER_BYTES + g;
        w = 0;
        if (a < base) return STS_RANGE;
        off = a - base;
        if (off < first_w * 4 || off > last_w * 4) return STS_RANGE;
        if (off & 3) return STS_NOBLK;
        w = off / 4;
        if (w >= STORE_WORDS || !hdr_ok[w]) return STS_NOBLK;
        return STS_OK;
    endfunction

    task automatic predict_heap_op(logic [1:0] fn_in, logic [12:0] req_in,
                                   logic [11:0] ad_in);
        int unsigned req, g, st, w, realn, cur, found, fs, k, nextlen, minr;
        int unsigned prev, bsize, nw, after, size, nx, nn, fl, pad, len, mn;
        bit have, ff;
        result_t r;
        req = req_in;
        g = cfg_guard & 8'hFC;
        st = STS_OK;
        w = 0;
        r = '0;
        if (func_t'(fn_in) == FN_INIT) begin
            len = cfg_len & ~3;
            mn = CONTROL_BYTES + HEADER_BYTES + 2 * g;
            if (len > ARENA_BYTES) len = ARENA_BYTES;
            if (len < mn) st = STS_NOMEM;
            else if (len == mn && !cfg_zero) st = STS_RANGE;
            else begin
                foreach (hdr_ok[i]) hdr_ok[i] = 1'b0;
                first_w = CONTROL_BYTES / 4;
                last_w = first_w;
                put_hdr(first_w, len - CONTROL_BYTES - HEADER_BYTES, 0, 0);
                ready = 1;
                free_total = len - CONTROL_BYTES - HEADER_BYTES;
                free_blocks = 1;
                used_total = 0;
                used_blocks = 0;
                live_addrs.delete();
                n_init_ok++;
            end
        end else if (!ready) begin
            st = STS_NOINIT;
        end else if (func_t'(fn_in) == FN_ALLOC) begin
            realn = ((req + 3) & ~3) + 2 * g;
            ff = (cfg_fit != FIT_BEST && cfg_fit != FIT_WORST);
            if (realn > free_total) st = STS_NOMEM;
            else if (req == 0 && !cfg_zero) st = STS_RANGE;
            else begin
                cur = first_w;
                found = 0;
                fs = 0;
                have = 0;
                for (k = 0; k < STORE_WORDS; k++) begin
                    if (!(hfl(cur) & USED_FLAG) && hsz(cur) >= realn) begin
                        if (!have) begin
                            have = 1;
                            found = cur;
                            fs = hsz(cur);
                            if (ff) break;
                        end else if ((cfg_fit == FIT_BEST && fs > hsz(cur)) ||
                                     (cfg_fit == FIT_WORST && fs < hsz(cur))) begin
                            found = cur;
                            fs = hsz(cur);
                        end
                    end
                    if (cur == last_w) break;
                    cur = hnx(cur);
                end
                if (!have) st = STS_NOMEM;
                else begin
                    nextlen = fs - realn;
                    minr = HEADER_BYTES + 2 * g;
                    prev = rd(found + 1);
                    if (nextlen > minr || (nextlen == minr && cfg_zero)) begin
                        nw = found + (HEADER_BYTES + realn) / 4;
                        after = found + (HEADER_BYTES + fs) / 4;
                        put_hdr(nw, nextlen - HEADER_BYTES, 0, found);
                        if (found == last_w) last_w = nw;
                        else wr(after + 1, nw);
                        bsize = realn;
                        free_total -= realn + HEADER_BYTES;
                    end else begin
                        bsize = fs;
                        free_total -= fs;
                        free_blocks--;
                    end
                    put_hdr(found, bsize, USED_FLAG | ((realn - 2 * g - req) & 8'h7F), prev);
                    used_total += bsize;
                    used_blocks++;
                    r.addr_out = 12'(found * 4 + HEADER_BYTES + g);
                    live_addrs.push_back(found * 4 + HEADER_BYTES + g);
                    n_alloc_ok++;
                end
            end
        end else if (func_t'(fn_in) == FN_FREE) begin
            st = locate(ad_in, g, w);
            if (st == STS_OK) n_free_ok++;
            if (st == STS_OK && (hfl(w) & USED_FLAG)) begin
                size = hsz(w);
                prev = rd(w + 1);
                put_hdr(w, size, 0, prev);
                used_total -= size;
                used_blocks--;
                free_total += size;
                free_blocks++;
                if (w != last_w) begin
                    nx = hnx(w);
                    if (!(hfl(nx) & USED_FLAG)) begin
                        nn = hnx(nx);
                        size += hsz(nx) + HEADER_BYTES;
                        if (nx < STORE_WORDS) hdr_ok[nx] = 1'b0;
                        if (nx == last_w) last_w = w;
                        else wr(nn + 1, w);
                        put_hdr(w, size, 0, prev);
                        free_total += HEADER_BYTES;
                        free_blocks--;
                    end
                end
                if (w != first_w && !(hfl(prev) & USED_FLAG)) begin
                    nn = hnx(w);
                    put_hdr(prev, hsz(prev) + size + HEADER_BYTES, 0, rd(prev + 1));
                    if (w < STORE_WORDS) hdr_ok[w] = 1'b0;
                    if (w == last_w) last_w = prev;
                    else wr(nn + 1, prev);
                    free_total += HEADER_BYTES;
                    free_blocks--;
                end
                last_freed = ad_in;
                foreach (live_addrs[i])
                    if (live_addrs[i] == ad_in) begin
                        live_addrs.delete(i);
                        break;
                    end
            end
        end else begin
            st = locate(ad_in, g, w);
            if (st == STS_OK) begin
                fl = hfl(w);
                pad = fl & 8'h7F;
                size = hsz(w);
                if (size < pad + 2 * g) st = STS_RANGE;
                else begin
                    n_query_ok++;
                    r.user_len = 13'(size - pad - 2 * g);
                    if (fl & USED_FLAG) begin
                        r.owned = 1'b1;
                        r.front_guard_addr = 12'(w * 4 + HEADER_BYTES);
                        r.back_guard_len = 9'(g + pad);
                        r.back_guard_addr = 12'(w * 4 + HEADER_BYTES + size - (g + pad));
                    end
                end
            end
        end
        r.status = status_t'(st[2:0]);
        r.free_bytes = 13'(free_total);
        r.free_count = 9'(free_blocks);
        r.used_bytes = 13'(used_total);
        r.used_count = 9'(used_blocks);
        expected_results.push_back(r);
    endtask

    // Driver: hold the item while stalled, otherwise advance or idle
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || !in_stall)
        begin
            if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle)
            begin
                heap_op_t op;
                op = pending_ops.pop_front();
                func <= op.fn;
                req_bytes <= op.req;
                addr <= op.ad;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            predict_heap_op(func, req_bytes, addr);
            n_items++;
        end
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_idle);

    task automatic report(string what, int unsigned got, int unsigned want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic cmp(string what, int unsigned got, int unsigned want);
        if (got != want) report(what, got, want);
    endtask

    // Monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                report("unexpected result, status", status, 0);
            else
            begin
                result_t e;
                e = expected_results.pop_front();
                cmp("status", status, e.status);
                cmp("addr_out", addr_out, e.addr_out);
                cmp("user_len", user_len, e.user_len);
                cmp("owned", owned, e.owned);
                cmp("front_guard_addr", front_guard_addr, e.front_guard_addr);
                cmp("back_guard_addr", back_guard_addr, e.back_guard_addr);
                cmp("back_guard_len", back_guard_len, e.back_guard_len);
                cmp("free_bytes", free_bytes, e.free_bytes);
                cmp("free_count", free_count, e.free_count);
                cmp("used_bytes", used_bytes, e.used_bytes);
                cmp("used_count", used_count, e.used_count);
            end
        end
    end

    task automatic push_op(func_t fn, int unsigned req, int unsigned ad);
        heap_op_t op;
        while (pending_ops.size() >= 4) @(posedge clk);
        op.fn = fn;
        op.req = 13'(req);
        op.ad = 12'(ad);
        pending_ops.push_back(op);
    endtask

    task automatic drain();
        while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int unsigned val);
        drain();
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'(idx * 4);
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_ARENA_LEN: cfg_len = val & 13'h1FFF;
            REG_FIT_MODE:  cfg_fit = val & 2'h3;
            REG_GUARD:     cfg_guard = val & 8'hFF;
            default:       cfg_zero = val & 1;
        endcase
    endtask

    task automatic random_ops(int n);
        int unsigned pick, req, ad;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 42)
            begin
                if ($urandom_range(9) == 0) req = $urandom_range(8191);
                else if ($urandom_range(9) == 0) req = 0;
                else req = $urandom_range(120);
                push_op(FN_ALLOC, req, $urandom_range(4095));
            end
            else if (pick < 94)
            begin
                if (live_addrs.size() != 0 && $urandom_range(9) != 0)
                    ad = live_addrs[$urandom_range(live_addrs.size() - 1)];
                else if ($urandom_range(1)) ad = last_freed;
                else ad = $urandom_range(4095);
                if ($urandom_range(19) == 0) ad = $urandom_range(4095);
                push_op(pick < 72 ? FN_FREE : FN_QUERY, $urandom_range(8191), ad);
            end
            else if (pick < 97)
                push_op(FN_INIT, $urandom_range(8191), $urandom_range(4095));
            else
                push_op(FN_QUERY, $urandom_range(8191), $urandom_range(4095));
        end
    endtask

    initial
    begin
        #200_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int unsigned fits[4] = '{0, 1, 2, 3};
        int unsigned guards[4] = '{0, 8, 255, 252};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        send_idle = 23;
        recv_idle = 80;

        // Before init nothing is served; then init and directed alloc, query and free cases
        push_op(FN_ALLOC, 4, 0);
        push_op(FN_FREE, 0, 100);
        push_op(FN_QUERY, 0, 100);
        push_op(FN_INIT, 0, 0);
        push_op(FN_ALLOC, 0, 0);
        push_op(FN_ALLOC, 4096, 0);
        push_op(FN_ALLOC, 13, 0);
        push_op(FN_ALLOC, 1, 0);
        push_op(FN_QUERY, 0, 64);
        push_op(FN_QUERY, 0, 0);
        push_op(FN_QUERY, 0, 66);
        push_op(FN_QUERY, 0, 4095);
        push_op(FN_FREE, 0, 96);
        push_op(FN_FREE, 0, 96);
        push_op(FN_FREE, 0, 64);
        push_op(FN_ALLOC, 4016, 0);
        // A guard widened after init changes where a query locates the block
        write_reg(REG_GUARD, 8);
        push_op(FN_QUERY, 0, 72);
        write_reg(REG_GUARD, 0);
        // Init too small, then exactly minimal without and with empty blocks
        write_reg(REG_ARENA_LEN, 60);
        push_op(FN_INIT, 0, 0);
        write_reg(REG_ARENA_LEN, 64);
        push_op(FN_INIT, 0, 0);
        write_reg(REG_ALLOW_ZERO, 1);
        push_op(FN_INIT, 0, 0);
        // Oversized arena saturates; payload lands at the arena end
        write_reg(REG_ARENA_LEN, 8191);
        push_op(FN_INIT, 0, 0);
        push_op(FN_ALLOC, 4016, 0);
        push_op(FN_ALLOC, 0, 0);
        push_op(FN_QUERY, 0, 64);

        for (int ph = 0; ph < 3; ph++)
        begin
            if (ph == 1)
            begin
                send_idle = 80;
                recv_idle = 23;
            end
            else if (ph == 2)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            for (int s = 0; s < 3; s++)
            begin
                write_reg(REG_FIT_MODE, fits[(ph + s) % 4]);
                write_reg(REG_GUARD, (s == 2) ? guards[ph + 1] : guards[s * ph % 2]);
                write_reg(REG_ALLOW_ZERO, (ph + s) % 2);
                write_reg(REG_ARENA_LEN, (s == 0) ? 4096 : $urandom_range(200, 8191));
                push_op(FN_INIT, 0, 0);
                random_ops(120);
            end
        end
        write_reg(REG_FIT_MODE, 3);
        write_reg(REG_ARENA_LEN, 0);
        push_op(FN_INIT, 0, 0);
        random_ops(30);

        drain();
        repeat (50) @(posedge clk);
        $display("%0d items checked: %0d allocs, %0d frees, %0d queries, %0d inits succeeded",
                 n_items, n_alloc_ok, n_free_ok, n_query_ok, n_init_ok);
        $display("fit modes 0-3, guards 0 to 255, zero allocs on and off, %0d mismatches",
                 errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
